@@ sv/oetsm_pkg.sv @@
`default_nettype none

package oetsm_pkg;

    // default sizing of the reference store
    localparam int MAX_TOKENS_DEF = 32;
    localparam int TOKEN_BITS_DEF = 7;

    // result flags of one candidate sequence
    typedef struct packed {
        logic identical;
        logic one_replaced;
        logic one_added;
        logic one_removed;
        logic overflow;
    } t_result;

endpackage

`default_nettype wire

@@ sv/oetsm_in_if.sv @@
`default_nettype none

interface oetsm_in_if #(
    parameter int TOKEN_BITS = oetsm_pkg::TOKEN_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [TOKEN_BITS-1:0] token;
    logic                  last;
    logic                  word_valid;
    logic                  is_query_word;

    modport source (
        output valid, req_type, token, last, word_valid, is_query_word,
        input  ready
    );

    modport sink (
        input  valid, req_type, token, last, word_valid, is_query_word,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/oetsm_out_if.sv @@
`default_nettype none

interface oetsm_out_if;
    logic valid;
    logic ready;
    logic identical;
    logic one_replaced;
    logic one_added;
    logic one_removed;
    logic overflow;

    modport source (
        output valid, identical, one_replaced, one_added, one_removed, overflow,
        input  ready
    );

    modport sink (
        input  valid, identical, one_replaced, one_added, one_removed, overflow,
        output ready
    );
endinterface

`default_nettype wire

@@ sv/oetsm_ram.sv @@
`default_nettype none

module oetsm_ram #(
    parameter int WIDTH = oetsm_pkg::TOKEN_BITS_DEF,
    parameter int DEPTH = oetsm_pkg::MAX_TOKENS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ sv/oetsm_result_buf.sv @@
`default_nettype none

module oetsm_result_buf (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire oetsm_pkg::t_result i_data,
    output logic                   o_full,
    oetsm_out_if.source            o_out
);

    logic               r_v0, r_v1, n_v0, n_v1;
    oetsm_pkg::t_result r_d0, r_d1, n_d0, n_d1;
    logic               pop;

    assign pop    = r_v0 && o_out.ready;
    assign o_full = r_v1;

    // head drives the port, second entry takes a beat while the head waits
    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_d0 = r_d0;
        n_d1 = r_d1;
        if (pop) begin
            n_v0 = r_v1;
            n_d0 = r_d1;
            n_v1 = 1'b0;
        end
        if (i_push) begin
            if (!n_v0) begin
                n_v0 = 1'b1;
                n_d0 = i_data;
            end else begin
                n_v1 = 1'b1;
                n_d1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0 <= n_d0;
        r_d1 <= n_d1;
    end

    assign o_out.valid        = r_v0;
    assign o_out.identical    = r_d0.identical;
    assign o_out.one_replaced = r_d0.one_replaced;
    assign o_out.one_added    = r_d0.one_added;
    assign o_out.one_removed  = r_d0.one_removed;
    assign o_out.overflow     = r_d0.overflow;

endmodule

`default_nettype wire

@@ sv/one_edit_token_sequence_matcher.sv @@
`default_nettype none

// Compares streamed candidate token sequences against a stored reference sequence and
// reports, on each candidate's last token, whether it is identical, differs by one
// replaced token, by one added token or by one removed token, or overflowed. Load beats
// (req_type 0) write the reference one token per beat; candidate beats (req_type 1) are
// compared as they arrive. Beats may follow back to back: the reference RAM has one read
// port, and each candidate beat prefetches the entry two places ahead while the current
// entry and the one before it sit in a small window register, so the three-way compare
// never waits on memory. Results leave through a two-entry buffer, so input is held off
// only when two results are waiting. The reference RAM needs no clearing after reset;
// entries beyond the loaded length are never compared.
module one_edit_token_sequence_matcher #(
    parameter int MAX_TOKENS = oetsm_pkg::MAX_TOKENS_DEF,
    parameter int TOKEN_BITS = oetsm_pkg::TOKEN_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    oetsm_in_if.sink    i_in,
    oetsm_out_if.source o_out
);

    localparam int AW = $clog2(MAX_TOKENS);
    localparam int PW = $clog2(MAX_TOKENS + 2);
    localparam logic [PW-1:0] MAXP  = PW'(MAX_TOKENS);
    localparam logic [PW-1:0] OVERP = PW'(MAX_TOKENS + 1);

    // control state
    logic          r_loading;
    logic          r_ovf;
    logic [PW-1:0] r_len;
    logic [PW-1:0] r_pos;
    logic [1:0]    r_mc;
    logic          r_prefix, r_insert, r_delete;

    // token window and head of reference
    logic [TOKEN_BITS-1:0] r_ref0, r_ref1, r_prev, r_here;

    logic                  fire, is_load, buf_full;
    logic [TOKEN_BITS-1:0] ram_rd;

    // load path
    logic [PW-1:0] ld_pos, ld_pos_next;
    logic          ld_room, ld_ovf, wr_en;

    // candidate path
    logic [PW-1:0]         c_len, c_pos, c_pos1, c_pos2, c_pos_next;
    logic [1:0]            c_mc, c_mc_next;
    logic                  c_prefix, c_insert, c_delete;
    logic                  c_prefix_next, c_insert_next, c_delete_next;
    logic                  c_room, at_zero, rd_en;
    logic [TOKEN_BITS-1:0] tok_here, tok_next;
    logic                  eq_here, eq_prev, eq_next;

    // result
    logic               push, res_ovf, same_len;
    oetsm_pkg::t_result res;

    assign i_in.ready = !buf_full;
    assign fire       = i_in.valid && i_in.ready;
    assign is_load    = !i_in.req_type;

    // load: a fresh load restarts at entry zero and clears overflow
    always_comb begin
        ld_pos      = r_loading ? r_pos : '0;
        ld_room     = ld_pos < MAXP;
        ld_pos_next = ld_room ? ld_pos + PW'(1) : ld_pos;
        ld_ovf      = (r_loading && r_ovf) || !ld_room;
        wr_en       = fire && is_load && ld_room;
    end

    // candidate: an unfinished load ends here, with a clean candidate state
    always_comb begin
        c_len    = r_loading ? r_pos : r_len;
        c_pos    = r_loading ? '0 : r_pos;
        c_mc     = r_loading ? 2'd0 : r_mc;
        c_prefix = r_loading || r_prefix;
        c_insert = !r_loading && r_insert;
        c_delete = !r_loading && r_delete;
        c_room   = c_pos < MAXP;
        at_zero  = c_pos == '0;
        c_pos1   = c_pos + PW'(1);
        c_pos2   = c_pos + PW'(2);
        tok_here = at_zero ? r_ref0 : r_here;
        tok_next = at_zero ? r_ref1 : ram_rd;
        eq_here  = (c_pos < c_len) && (tok_here == i_in.token);
        eq_prev  = !at_zero && (c_pos <= c_len) && (r_prev == i_in.token);
        eq_next  = (c_pos1 < c_len) && (tok_next == i_in.token);
        rd_en    = fire && !is_load && c_room && (c_pos2 < MAXP);

        c_mc_next     = c_mc;
        c_prefix_next = c_prefix;
        c_insert_next = c_insert;
        c_delete_next = c_delete;
        c_pos_next    = OVERP;
        if (c_room) begin
            if (!eq_here && c_mc != 2'd3) begin
                c_mc_next = c_mc + 2'd1;
            end
            c_prefix_next = c_prefix && eq_here;
            c_insert_next = c_prefix || (c_insert && eq_prev);
            c_delete_next = (c_prefix || c_delete) && eq_next;
            c_pos_next    = c_pos1;
        end
    end

    // result flags on the candidate's last token
    always_comb begin
        push     = fire && !is_load && i_in.last;
        res_ovf  = r_ovf || (c_pos_next == OVERP);
        same_len = c_pos_next == c_len;
        res.overflow     = res_ovf;
        res.identical    = !res_ovf && same_len && (c_mc_next == 2'd0) && !i_in.is_query_word;
        res.one_replaced = !res_ovf && i_in.word_valid && same_len && (c_mc_next == 2'd1);
        res.one_added    = !res_ovf && i_in.word_valid && (c_pos_next == c_len + PW'(1))
                           && c_insert_next;
        res.one_removed  = !res_ovf && i_in.word_valid
                           && (({1'b0, c_pos_next} + (PW+1)'(1)) == {1'b0, c_len})
                           && (c_delete_next || c_prefix_next);
    end

    // control state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loading <= 1'b0;
            r_ovf     <= 1'b0;
            r_len     <= '0;
            r_pos     <= '0;
            r_mc      <= 2'd0;
            r_prefix  <= 1'b1;
            r_insert  <= 1'b0;
            r_delete  <= 1'b0;
        end else if (fire) begin
            if (is_load) begin
                r_loading <= !i_in.last;
                r_ovf     <= ld_ovf;
                r_pos     <= i_in.last ? '0 : ld_pos_next;
                if (i_in.last) begin
                    r_len <= ld_pos_next;
                end
                r_mc     <= 2'd0;
                r_prefix <= 1'b1;
                r_insert <= 1'b0;
                r_delete <= 1'b0;
            end else begin
                r_loading <= 1'b0;
                r_len     <= c_len;
                if (i_in.last) begin
                    r_pos    <= '0;
                    r_mc     <= 2'd0;
                    r_prefix <= 1'b1;
                    r_insert <= 1'b0;
                    r_delete <= 1'b0;
                end else begin
                    r_pos    <= c_pos_next;
                    r_mc     <= c_mc_next;
                    r_prefix <= c_prefix_next;
                    r_insert <= c_insert_next;
                    r_delete <= c_delete_next;
                end
            end
        end
    end

    // window shift and copies of the first two reference entries
    always_ff @(posedge i_clk) begin
        if (fire && !is_load) begin
            r_prev <= tok_here;
            r_here <= tok_next;
        end
        if (wr_en && ld_pos == '0) begin
            r_ref0 <= i_in.token;
        end
        if (wr_en && ld_pos == PW'(1)) begin
            r_ref1 <= i_in.token;
        end
    end

    oetsm_ram #(
        .WIDTH(TOKEN_BITS),
        .DEPTH(MAX_TOKENS)
    ) u_ref_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(ld_pos[AW-1:0]),
        .i_wr_data(i_in.token),
        .i_rd_en  (rd_en),
        .i_rd_addr(c_pos2[AW-1:0]),
        .o_rd_data(ram_rd)
    );

    oetsm_result_buf u_result_buf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (res),
        .o_full (buf_full),
        .o_out  (o_out)
    );

    // an overflowed result carries no match flags
    a_ovf_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |->
        !(o_out.identical || o_out.one_replaced || o_out.one_added || o_out.one_removed))
        else $error("overflow result with match flags set");

    // identical and one replaced need different mismatch counts
    a_ident_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.identical && o_out.one_replaced))
        else $error("identical and one_replaced both set");

    // added and removed need different lengths
    a_add_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !(o_out.one_added && o_out.one_removed))
        else $error("one_added and one_removed both set");

    // a finished candidate leaves a clean state behind
    a_cand_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !is_load && i_in.last) |=>
        (r_pos == '0 && r_mc == 2'd0 && r_prefix && !r_insert && !r_delete && !r_loading))
        else $error("candidate state not cleared after last beat");

    // position never passes the overflow mark, length never passes the store
    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= OVERP) && (r_len <= MAXP))
        else $error("position or length out of range");

endmodule

`default_nettype wire

@@ tb/tb_one_edit_token_sequence_matcher.sv @@
`timescale 1ns / 1ps

module tb_one_edit_token_sequence_matcher;

    localparam int MAX_TOKENS   = oetsm_pkg::MAX_TOKENS_DEF;
    localparam int TOKEN_BITS   = oetsm_pkg::TOKEN_BITS_DEF;
    localparam int CAND_OVER    = MAX_TOKENS + 1;
    localparam int ITEMS_TARGET = 1950;
    localparam int IDLE_PCT     = 22;

    // request kinds carried in req_type
    localparam bit REQ_LOAD = 1'b0;
    localparam bit REQ_CAND = 1'b1;

    typedef logic [TOKEN_BITS-1:0] t_token;

    logic i_clk;
    logic i_rst_n;

    oetsm_in_if #(.TOKEN_BITS(TOKEN_BITS)) in_bus ();
    oetsm_out_if                           out_bus ();

    one_edit_token_sequence_matcher #(
        .MAX_TOKENS(MAX_TOKENS),
        .TOKEN_BITS(TOKEN_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // shadow copy of the matcher state
    t_token ref_tok [MAX_TOKENS];
    int     ref_len;
    int     cand_pos;
    int     n_diff;
    bit     on_prefix;
    bit     ins_ok;
    bit     del_ok;
    bit     ref_over;
    bit     load_busy;

    // flags still owed by the block, oldest first
    oetsm_pkg::t_result flags_due [$];

    // stimulus buffers: tokens of the next sequence and the reference as sent
    t_token seq_buf  [$];
    t_token ref_copy [$];

    int errors;
    int beats_sent;
    int results_seen;
    int n_ident, n_repl, n_add, n_rem, n_ovf;
    bit steady;
    int hold_len;

    oetsm_pkg::t_result want;
    oetsm_pkg::t_result got;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic bit ref_match(input int idx, input t_token tok);
        if (idx < 0 || idx >= ref_len || idx >= MAX_TOKENS)
            return 1'b0;
        return ref_tok[idx] == tok;
    endfunction

    task automatic clear_candidate();
        cand_pos  = 0;
        n_diff    = 0;
        on_prefix = 1'b1;
        ins_ok    = 1'b0;
        del_ok    = 1'b0;
    endtask

    // advance the shadow state by one accepted beat, queue flags on a candidate's end
    task automatic score_beat(input bit kind, input t_token tok, input bit lst,
                              input bit wv, input bit qw);
        oetsm_pkg::t_result res;
        bit eq_here, eq_prev, eq_next, nxt_ins, nxt_del, ovf_now, same_len;
        int i;
        if (kind == REQ_LOAD) begin
            // first load beat starts a fresh reference
            if (!load_busy) begin
                load_busy = 1'b1;
                ref_over  = 1'b0;
                cand_pos  = 0;
            end
            if (cand_pos < MAX_TOKENS) begin
                ref_tok[cand_pos] = tok;
                cand_pos++;
            end else begin
                ref_over = 1'b1;
            end
            if (lst) begin
                ref_len   = cand_pos;
                load_busy = 1'b0;
                clear_candidate();
            end
        end else begin
            // a candidate closes any open load
            if (load_busy) begin
                ref_len   = cand_pos;
                load_busy = 1'b0;
                clear_candidate();
            end
            if (cand_pos >= MAX_TOKENS) begin
                cand_pos = CAND_OVER;
            end else begin
                i       = cand_pos;
                eq_here = ref_match(i, tok);
                eq_prev = (i >= 1) && ref_match(i - 1, tok);
                eq_next = ref_match(i + 1, tok);
                nxt_ins = on_prefix || (ins_ok && eq_prev);
                nxt_del = (on_prefix || del_ok) && eq_next;
                if (!eq_here && n_diff < 3)
                    n_diff++;
                on_prefix = on_prefix && eq_here;
                ins_ok    = nxt_ins;
                del_ok    = nxt_del;
                cand_pos  = i + 1;
            end
            if (lst) begin
                ovf_now  = ref_over || (cand_pos == CAND_OVER);
                same_len = (cand_pos == ref_len);
                res      = '0;
                if (!ovf_now) begin
                    res.identical    = same_len && n_diff == 0 && !qw;
                    res.one_replaced = wv && same_len && n_diff == 1;
                    res.one_added    = wv && cand_pos == ref_len + 1 && ins_ok;
                    res.one_removed  = wv && cand_pos + 1 == ref_len && (del_ok || on_prefix);
                end
                res.overflow = ovf_now;
                flags_due.push_back(res);
                clear_candidate();
            end
        end
    endtask

    // ---------------------------------------------------------------- driving

    // offer one beat, with random gaps, and score it once taken
    task automatic send_beat(input bit kind, input t_token tok, input bit lst,
                             input bit wv, input bit qw);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_bus.valid         <= 1'b1;
        in_bus.req_type      <= kind;
        in_bus.token         <= tok;
        in_bus.last          <= lst;
        in_bus.word_valid    <= wv;
        in_bus.is_query_word <= qw;
        @(posedge i_clk);
        while (in_bus.ready !== 1'b1)
            @(posedge i_clk);
        score_beat(kind, tok, lst, wv, qw);
        beats_sent++;
    endtask

    // send seq_buf as one sequence; close marks its final beat as last
    task automatic send_seq(input bit kind, input bit close, input bit wv, input bit qw);
        int k;
        for (k = 0; k < seq_buf.size(); k++)
            send_beat(kind, seq_buf[k], close && (k == seq_buf.size() - 1), wv, qw);
    endtask

    task automatic load_reference(input bit close);
        seq_buf = ref_copy;
        send_seq(REQ_LOAD, close, 1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    // result sink: random stalls, or a long hold when asked
    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                out_bus.ready <= 1'b0;
                repeat (hold_len - 1) @(posedge i_clk);
                hold_len = 0;
            end else begin
                out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_flag(input string name, input bit w, input bit g);
        if (w !== g) begin
            errors++;
            $display("%0t: %s mismatch, expected %b, got %b", $time, name, w, g);
        end
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
                got.identical    = out_bus.identical;
                got.one_replaced = out_bus.one_replaced;
                got.one_added    = out_bus.one_added;
                got.one_removed  = out_bus.one_removed;
                got.overflow     = out_bus.overflow;
                results_seen++;
                if (flags_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing due, expected none, got %b",
                             $time, got);
                end else begin
                    want = flags_due.pop_front();
                    check_flag("identical",    want.identical,    got.identical);
                    check_flag("one_replaced", want.one_replaced, got.one_replaced);
                    check_flag("one_added",    want.one_added,    got.one_added);
                    check_flag("one_removed",  want.one_removed,  got.one_removed);
                    check_flag("overflow",     want.overflow,     got.overflow);
                end
                n_ident += int'(got.identical);
                n_repl  += int'(got.one_replaced);
                n_add   += int'(got.one_added);
                n_rem   += int'(got.one_removed);
                n_ovf   += int'(got.overflow);
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // nothing loaded yet: only a one-token candidate can be an addition
    task automatic test_empty_reference();
        seq_buf = '{7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        send_seq(REQ_CAND, 1'b1, 1'b0, 1'b1);
        seq_buf = '{7'd1, 7'd2};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
    endtask

    // each kind of single edit against a short reference
    task automatic test_single_edits();
        ref_copy = '{7'd0, 7'd127, 7'd5};
        load_reference(1'b1);
        seq_buf = '{7'd0, 7'd127, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        send_seq(REQ_CAND, 1'b1, 1'b0, 1'b1);
        seq_buf = '{7'd0, 7'd126, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        send_seq(REQ_CAND, 1'b1, 1'b0, 1'b0);
        seq_buf = '{7'd9, 7'd0, 7'd127, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b1);
        seq_buf = '{7'd0, 7'd127, 7'd127, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = '{7'd127, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = '{7'd0, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = '{7'd1, 7'd2, 7'd3};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        ref_copy = '{7'd42};
        load_reference(1'b1);
        seq_buf = '{7'd42, 7'd42};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = '{7'd7};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b1);
    endtask

    // a candidate beat while a load is still open ends that load
    task automatic test_open_load();
        ref_copy = '{7'd3, 7'd4, 7'd5};
        load_reference(1'b0);
        seq_buf = '{7'd3, 7'd4, 7'd5};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = '{7'd3, 7'd4};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
    endtask

    // too long a reference, then too long a candidate
    task automatic test_overflow();
        int k;
        ref_copy.delete();
        for (k = 0; k < MAX_TOKENS + 1; k++)
            ref_copy.push_back(t_token'($urandom()));
        load_reference(1'b1);
        seq_buf = '{ref_copy[0]};
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        // a new load clears the overflow
        void'(ref_copy.pop_back());
        load_reference(1'b1);
        seq_buf = ref_copy;
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf.push_back(t_token'($urandom()));
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
        seq_buf = ref_copy;
        void'(seq_buf.pop_back());
        send_seq(REQ_CAND, 1'b1, 1'b1, 1'b0);
    endtask

    // hold the result side off while one-token candidates keep coming
    task automatic test_backpressure();
        int k;
        steady   = 1'b1;
        ref_copy = '{7'd11};
        load_reference(1'b1);
        hold_len = 60;
        for (k = 0; k < 16; k++)
            send_beat(REQ_CAND, 7'd11 + t_token'(k[1:0]), 1'b1, k[0], k[1]);
        steady = 1'b0;
    endtask

    // derive a candidate from the current reference with random edits
    task automatic make_candidate();
        int p, pick, n, k;
        t_token t;
        seq_buf = ref_copy;
        pick    = $urandom_range(99);
        if (pick < 15) begin
            // unchanged
        end else if (pick < 32) begin
            p = $urandom_range(seq_buf.size() - 1);
            seq_buf[p] = $urandom_range(1) ? seq_buf[p] ^ t_token'($urandom_range(127, 1))
                                           : seq_buf[p] + t_token'(1);
        end else if (pick < 50) begin
            p = $urandom_range(seq_buf.size());
            t = $urandom_range(1) ? ref_copy[$urandom_range(ref_copy.size() - 1)]
                                  : t_token'($urandom());
            seq_buf.insert(p, t);
        end else if (pick < 68) begin
            p = $urandom_range(seq_buf.size() - 1);
            seq_buf.delete(p);
        end else if (pick < 80) begin
            for (k = 0; k < 2; k++) begin
                p = $urandom_range(seq_buf.size() - 1);
                seq_buf[p] = seq_buf[p] + t_token'(1);
            end
        end else if (pick < 96) begin
            n = $urandom_range(ref_copy.size() + 2, 1);
            seq_buf.delete();
            for (k = 0; k < n; k++)
                seq_buf.push_back($urandom_range(1)
                                  ? ref_copy[$urandom_range(ref_copy.size() - 1)]
                                  : t_token'($urandom()));
        end else begin
            n = $urandom_range(MAX_TOKENS + 2, MAX_TOKENS + 1);
            while (seq_buf.size() < n)
                seq_buf.push_back(t_token'($urandom()));
        end
        if (seq_buf.size() == 0)
            seq_buf.push_back(t_token'($urandom()));
    endtask

    // random references, each followed by a handful of near-miss candidates
    task automatic test_random_sequences();
        int n, k, r, len;
        bit narrow;
        t_token base;
        while (beats_sent < ITEMS_TARGET) begin
            steady = (beats_sent >= 800 && beats_sent < 1100);
            r      = $urandom_range(99);
            if (r < 8) begin
                // stray beats of any shape
                n = $urandom_range(6, 1);
                for (k = 0; k < n; k++)
                    send_beat(1'($urandom_range(1)), t_token'($urandom()),
                              $urandom_range(99) < 30,
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            end else begin
                narrow = 1'($urandom_range(1));
                base   = t_token'($urandom());
                r      = $urandom_range(99);
                len    = (r < 80) ? $urandom_range(8, 1) :
                         (r < 95) ? $urandom_range(MAX_TOKENS, 9) :
                                    $urandom_range(MAX_TOKENS + 2, MAX_TOKENS + 1);
                ref_copy.delete();
                for (k = 0; k < len; k++)
                    ref_copy.push_back(narrow ? base + t_token'($urandom_range(2))
                                              : t_token'($urandom()));
                load_reference($urandom_range(99) >= 6);
                n = $urandom_range(8, 3);
                for (k = 0; k < n; k++) begin
                    make_candidate();
                    send_seq(REQ_CAND, 1'b1, $urandom_range(99) < 85,
                             $urandom_range(99) < 25);
                end
            end
        end
        steady = 1'b0;
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        int guard;
        errors       = 0;
        beats_sent   = 0;
        results_seen = 0;
        n_ident      = 0;
        n_repl       = 0;
        n_add        = 0;
        n_rem        = 0;
        n_ovf        = 0;
        steady       = 1'b0;
        hold_len     = 0;
        ref_len      = 0;
        ref_over     = 1'b0;
        load_busy    = 1'b0;
        clear_candidate();

        i_rst_n              <= 1'b0;
        in_bus.valid         <= 1'b0;
        in_bus.req_type      <= REQ_LOAD;
        in_bus.token         <= '0;
        in_bus.last          <= 1'b0;
        in_bus.word_valid    <= 1'b0;
        in_bus.is_query_word <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_reference();
        test_single_edits();
        test_open_load();
        test_overflow();
        test_backpressure();
        test_random_sequences();

        in_bus.valid <= 1'b0;
        guard = 0;
        while (flags_due.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (flags_due.size() != 0) begin
            errors += flags_due.size();
            $display("%0t: %0d results never arrived, expected none left, got %0d",
                     $time, flags_due.size(), flags_due.size());
        end

        $display("summary: %0d beats sent, %0d results checked, %0d mismatches",
                 beats_sent, results_seen, errors);
        $display("summary: identical %0d, replaced %0d, added %0d, removed %0d, overflow %0d",
                 n_ident, n_repl, n_add, n_rem, n_ovf);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ sim.f @@
sv/oetsm_pkg.sv
sv/oetsm_in_if.sv
sv/oetsm_out_if.sv
sv/oetsm_ram.sv
sv/oetsm_result_buf.sv
sv/one_edit_token_sequence_matcher.sv
tb/tb_one_edit_token_sequence_matcher.sv
